// ===== rtl/row_run_line_classifier_unit_assert.svh =====
// ----------------------------------------------------------------------------
// row_run_line_classifier_unit_assert
// Assertion macros for the row run line classifier.
// ----------------------------------------------------------------------------
`ifndef ROW_RUN_LINE_CLASSIFIER_UNIT_ASSERT_SVH
`define ROW_RUN_LINE_CLASSIFIER_UNIT_ASSERT_SVH

// same-cycle implication
`define RRLC_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RRLC_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/rrlc_pkg.sv =====
// ----------------------------------------------------------------------------
// rrlc_pkg
// Shared types and constants of the row run line classifier.
// ----------------------------------------------------------------------------
package rrlc_pkg;

   localparam int MAX_COLUMNS = 2048;
   localparam int COL_W       = $clog2(MAX_COLUMNS);
   localparam int CMP_W       = COL_W + 2;
   localparam int LEN_W       = 12;
   localparam int POS_W       = 12;
   localparam int CSR_W       = 12;
   localparam int IDX_W       = 2;

   localparam logic [IDX_W-1:0] REG_LINE_WIDTH     = 2'd0;
   localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH    = 2'd1;
   localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT   = 2'd2;
   localparam logic [IDX_W-1:0] REG_LINE_THRESHOLD = 2'd3;

   localparam logic [10:0] RST_LINE_WIDTH     = 11'd50;
   localparam logic [11:0] RST_IMAGE_WIDTH    = 12'd320;
   localparam logic [11:0] RST_IMAGE_HEIGHT   = 12'd240;
   localparam logic [7:0]  RST_LINE_THRESHOLD = 8'd128;

   localparam logic [2:0] KIND_NONE       = 3'd0;
   localparam logic [2:0] KIND_VERTICAL   = 3'd1;
   localparam logic [2:0] KIND_LEFT       = 3'd2;
   localparam logic [2:0] KIND_RIGHT      = 3'd3;
   localparam logic [2:0] KIND_LEFT_RIGHT = 3'd4;

   localparam logic signed [POS_W-1:0] NONE_POS = 12'hFFF;

   typedef struct packed {
      logic [7:0] pixel;
      logic       row_last;
   } rrlc_req_type;

   typedef struct packed {
      logic [2:0]              kind;
      logic signed [POS_W-1:0] start_x;
      logic signed [POS_W-1:0] end_x;
      logic signed [POS_W-1:0] row_y;
      logic signed [POS_W-1:0] midpoint_x;
   } rrlc_rsp_type;

   // run seen by the classifier on the word that closes it
   typedef struct packed {
      logic             emit;
      logic             found;
      logic [COL_W-1:0] start;
      logic [LEN_W-1:0] length;
      logic [POS_W-1:0] end_col;
   } rrlc_run_type;

endpackage

// ===== rtl/rrlc_tracker.sv =====
// ----------------------------------------------------------------------------
// rrlc_tracker
// Column counter and first-run tracker for one image row.
// ----------------------------------------------------------------------------
module rrlc_tracker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  rrlc_pkg::rrlc_req_type word,
   input  logic [7:0]           line_threshold,
   input  logic [11:0]          image_width,
   output rrlc_pkg::rrlc_run_type run
);

   logic [rrlc_pkg::COL_W-1:0] column_ff, column_in;
   logic                       run_found_ff, run_found_in;
   logic [rrlc_pkg::COL_W-1:0] run_start_ff, run_start_in;
   logic [rrlc_pkg::LEN_W-1:0] run_length_ff, run_length_in;
   logic                       row_done_ff, row_done_in;

   logic                       is_line;
   logic                       last;
   logic [rrlc_pkg::CMP_W-1:0] col_next;
   logic [rrlc_pkg::LEN_W-1:0] len_inc;
   logic [rrlc_pkg::POS_W-1:0] width_last;

   assign is_line    = word.pixel >= line_threshold;
   assign col_next   = rrlc_pkg::CMP_W'(column_ff) + rrlc_pkg::CMP_W'(1);
   assign last       = word.row_last
                       || (col_next >= rrlc_pkg::CMP_W'(image_width))
                       || (column_ff == rrlc_pkg::COL_W'(rrlc_pkg::MAX_COLUMNS - 1));
   assign len_inc    = (run_length_ff == '1) ? run_length_ff : run_length_ff + 1'b1;
   assign width_last = image_width - 12'd1;

   always_comb begin
      run              = '0;
      run.found        = run_found_ff;
      run.start        = run_start_ff;
      run.length       = run_length_ff;
      run.end_col      = width_last;
      run_found_in     = run_found_ff;
      run_start_in     = run_start_ff;
      run_length_in    = run_length_ff;
      row_done_in      = row_done_ff;
      if (!row_done_ff) begin
         if (is_line) begin
            run.found = 1'b1;
            if (!run_found_ff) begin
               run.start  = column_ff;
               run.length = rrlc_pkg::LEN_W'(1);
            end else begin
               run.length = len_inc;
            end
            run.emit      = last;
            run_found_in  = 1'b1;
            run_start_in  = run.start;
            run_length_in = run.length;
         end else if (run_found_ff) begin
            run.emit    = 1'b1;
            run.end_col = rrlc_pkg::POS_W'(column_ff);
            row_done_in = 1'b1;
         end else begin
            run.emit = last;
         end
      end
      if (last) begin
         column_in     = '0;
         run_found_in  = 1'b0;
         run_start_in  = '0;
         run_length_in = '0;
         row_done_in   = 1'b0;
      end else begin
         column_in = column_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff     <= '0;
         run_found_ff  <= 1'b0;
         run_start_ff  <= '0;
         run_length_ff <= '0;
         row_done_ff   <= 1'b0;
      end else if (step) begin
         column_ff     <= column_in;
         run_found_ff  <= run_found_in;
         run_start_ff  <= run_start_in;
         run_length_ff <= run_length_in;
         row_done_ff   <= row_done_in;
      end
   end

endmodule

// ===== rtl/rrlc_classify.sv =====
// ----------------------------------------------------------------------------
// rrlc_classify
// Sorts a finished run into vertical, left, right or left-right turn, or none.
// ----------------------------------------------------------------------------
module rrlc_classify (
   input  rrlc_pkg::rrlc_run_type run,
   input  logic [10:0]            line_width,
   input  logic [11:0]            image_width,
   input  logic [11:0]            image_height,
   output rrlc_pkg::rrlc_rsp_type result
);

   localparam int M_W = 17;

   logic [M_W-1:0] l, e, s, w, h;
   logic [M_W-1:0] l5, l10, e2, e4, e6, w7, s10;
   logic           is_vert, is_turn, is_lr;
   logic [2:0]     kind;

   assign l   = M_W'(run.length);
   assign e   = M_W'(line_width);
   assign s   = M_W'(run.start);
   assign w   = M_W'(image_width);
   assign h   = M_W'(image_height);
   assign l5  = (l << 2) + l;
   assign l10 = l5 << 1;
   assign e2  = e << 1;
   assign e4  = e << 2;
   assign e6  = (e << 2) + (e << 1);
   assign w7  = (w << 3) - w;
   assign s10 = (s << 3) + (s << 1);

   assign is_vert = (l5 >= e4) && (l5 <= e6);
   assign is_turn = (l >= e2) && (l10 <= w7);
   assign is_lr   = (l >= e4) && (s10 <= h);

   always_comb begin
      kind = rrlc_pkg::KIND_NONE;
      if (run.found) begin
         if (is_vert) begin
            kind = rrlc_pkg::KIND_VERTICAL;
         end else if (is_turn && (s10 <= w)) begin
            kind = rrlc_pkg::KIND_LEFT;
         end else if (is_turn) begin
            kind = rrlc_pkg::KIND_RIGHT;
         end else if (is_lr) begin
            kind = rrlc_pkg::KIND_LEFT_RIGHT;
         end
      end
   end

   always_comb begin
      result.kind = kind;
      if (kind == rrlc_pkg::KIND_NONE) begin
         result.start_x    = rrlc_pkg::NONE_POS;
         result.end_x      = rrlc_pkg::NONE_POS;
         result.row_y      = rrlc_pkg::NONE_POS;
         result.midpoint_x = rrlc_pkg::NONE_POS;
      end else begin
         result.start_x    = rrlc_pkg::POS_W'(run.start);
         result.end_x      = run.end_col;
         result.row_y      = image_height - 12'd1;
         result.midpoint_x = rrlc_pkg::POS_W'(rrlc_pkg::POS_W'(run.start)
                                               + (run.length >> 1));
      end
   end

endmodule

// ===== rtl/row_run_line_classifier_unit.sv =====
// ----------------------------------------------------------------------------
// row_run_line_classifier_unit
// Finds the first line run in the bottom image row and classifies it.
//
// Usage:
//   req_* carries one pixel word per handshake, left to right, row_last on
//   the final pixel of the row. The row also ends at column image_width-1.
//   rsp_* carries one word per row: when the first run of pixels at or above
//   line_threshold ends, or at row end if no run closed earlier.
//   csr_* writes line_width, image_width, image_height, line_threshold;
//   write only while the block is idle.
// Timing:
//   A pixel is held in the input register, then the run update and
//   classification land in the result register, which drives rsp_valid;
//   a stall on rsp_ready can hold the pixel between those registers.
//   One pixel per cycle sustained while rsp_ready stays high.
// Reset clears the row state, both valid flags and loads the register
//   defaults (50, 320, 240, 128).
// A stall on rsp_ready holds the result and freezes the input register;
//   req_ready drops while that register is full during the stall.
// ----------------------------------------------------------------------------
`include "row_run_line_classifier_unit_assert.svh"

module row_run_line_classifier_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  rrlc_pkg::rrlc_req_type             req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output rrlc_pkg::rrlc_rsp_type             rsp_data,
   input  logic                               csr_we,
   input  logic [rrlc_pkg::IDX_W-1:0]         csr_index,
   input  logic [rrlc_pkg::CSR_W-1:0]         csr_wdata
);

   logic [10:0] line_width_ff;
   logic [11:0] image_width_ff;
   logic [11:0] image_height_ff;
   logic [7:0]  line_threshold_ff;

   logic                   in_valid_ff, in_valid_in;
   rrlc_pkg::rrlc_req_type in_data_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   rrlc_pkg::rrlc_rsp_type rsp_data_ff;

   logic                   stall;
   logic                   step;
   logic                   accept;
   rrlc_pkg::rrlc_run_type run;
   rrlc_pkg::rrlc_rsp_type result;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff     <= rrlc_pkg::RST_LINE_WIDTH;
         image_width_ff    <= rrlc_pkg::RST_IMAGE_WIDTH;
         image_height_ff   <= rrlc_pkg::RST_IMAGE_HEIGHT;
         line_threshold_ff <= rrlc_pkg::RST_LINE_THRESHOLD;
      end else if (csr_we) begin
         unique case (csr_index)
            rrlc_pkg::REG_LINE_WIDTH:     line_width_ff     <= csr_wdata[10:0];
            rrlc_pkg::REG_IMAGE_WIDTH:    image_width_ff    <= csr_wdata[11:0];
            rrlc_pkg::REG_IMAGE_HEIGHT:   image_height_ff   <= csr_wdata[11:0];
            rrlc_pkg::REG_LINE_THRESHOLD: line_threshold_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   assign stall     = rsp_valid_ff && !rsp_ready;
   assign step      = in_valid_ff && !stall;
   assign req_ready = !in_valid_ff || !stall;
   assign accept    = req_valid && req_ready;

   assign in_valid_in  = accept ? 1'b1 : (step ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = stall ? 1'b1 : (step && run.emit);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= req_data;
      end
      if (step && run.emit) begin
         rsp_data_ff <= result;
      end
   end

   rrlc_tracker u_tracker (
      .clock          (clock),
      .reset          (reset),
      .step           (step),
      .word           (in_data_ff),
      .line_threshold (line_threshold_ff),
      .image_width    (image_width_ff),
      .run            (run)
   );

   rrlc_classify u_classify (
      .run          (run),
      .line_width   (line_width_ff),
      .image_width  (image_width_ff),
      .image_height (image_height_ff),
      .result       (result)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `RRLC_ASSERT_IMP(a_none_fields, clock, reset,
      rsp_valid_ff && (rsp_data_ff.kind == rrlc_pkg::KIND_NONE),
      (rsp_data_ff.start_x == rrlc_pkg::NONE_POS) && (rsp_data_ff.end_x == rrlc_pkg::NONE_POS)
      && (rsp_data_ff.row_y == rrlc_pkg::NONE_POS)
      && (rsp_data_ff.midpoint_x == rrlc_pkg::NONE_POS),
      "kind none with a position field set")
   `RRLC_ASSERT_IMP(a_mid_order, clock, reset,
      rsp_valid_ff && (rsp_data_ff.kind != rrlc_pkg::KIND_NONE),
      (rsp_data_ff.midpoint_x >= rsp_data_ff.start_x) && (rsp_data_ff.start_x >= 0),
      "midpoint before run start")
   `RRLC_ASSERT_NXT(a_in_hold, clock, reset,
      in_valid_ff && stall,
      in_valid_ff,
      "input word dropped during result stall")

endmodule
